// ----- rtl/clti_pkg.sv -----
// ---------------------------------------------------------------------------
// clti_pkg
// Shared types and constants for the core-local timer interruptor.
// ---------------------------------------------------------------------------
package clti_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // register select codes
    localparam logic [1:0] REG_NONE = 2'd0;
    localparam logic [1:0] REG_SOFT = 2'd1;
    localparam logic [1:0] REG_CMP  = 2'd2;
    localparam logic [1:0] REG_TIME = 2'd3;

    // address windows
    localparam logic [15:0] SOFT_HI = 16'h0003;
    localparam logic [15:0] CMP_LO  = 16'h4000;
    localparam logic [15:0] CMP_HI  = 16'h4007;
    localparam logic [15:0] TIME_LO = 16'hbff8;
    localparam logic [15:0] TIME_HI = 16'hbfff;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] offset;
        logic [7:0]  write_byte;
        logic        timer_irq_enable;
        logic        soft_irq_enable;
    } t_item;

    typedef struct packed {
        logic [1:0] region;
        logic [2:0] lane;
    } t_loc;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       bad_offset;
        logic       timer_pending;
        logic       soft_pending;
    } t_result;

endpackage

// ----- rtl/clti_in_if.sv -----
// ---------------------------------------------------------------------------
// clti_in_if
// Request channel: tick, byte read or byte write words.
// ---------------------------------------------------------------------------
interface clti_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] offset;
    logic [7:0]  write_byte;
    logic        timer_irq_enable;
    logic        soft_irq_enable;

    modport source (
        output valid, command, offset, write_byte, timer_irq_enable, soft_irq_enable,
        input  ready
    );
    modport sink (
        input  valid, command, offset, write_byte, timer_irq_enable, soft_irq_enable,
        output ready
    );
endinterface

// ----- rtl/clti_out_if.sv -----
// ---------------------------------------------------------------------------
// clti_out_if
// Response channel: read data, error flag and interrupt pulses.
// ---------------------------------------------------------------------------
interface clti_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       bad_offset;
    logic       timer_pending;
    logic       soft_pending;

    modport source (
        output valid, read_byte, bad_offset, timer_pending, soft_pending,
        input  ready
    );
    modport sink (
        input  valid, read_byte, bad_offset, timer_pending, soft_pending,
        output ready
    );
endinterface

// ----- rtl/clti_decode.sv -----
// ---------------------------------------------------------------------------
// clti_decode
// Maps a byte offset to a register select and byte lane.
// ---------------------------------------------------------------------------
module clti_decode
    import clti_pkg::*;
(
    input  logic [15:0] i_offset,
    output t_loc        o_loc
);

    always_comb begin
        o_loc.region = REG_NONE;
        o_loc.lane   = 3'd0;
        if (i_offset <= SOFT_HI) begin
            o_loc.region = REG_SOFT;
            o_loc.lane   = {1'b0, i_offset[1:0]};
        end else if (i_offset >= CMP_LO && i_offset <= CMP_HI) begin
            o_loc.region = REG_CMP;
            o_loc.lane   = i_offset[2:0];
        end else if (i_offset >= TIME_LO && i_offset <= TIME_HI) begin
            o_loc.region = REG_TIME;
            o_loc.lane   = i_offset[2:0];
        end
    end

endmodule

// ----- rtl/clti_regs.sv -----
// ---------------------------------------------------------------------------
// clti_regs
// Soft word, compare and time registers with byte access and tick logic.
// ---------------------------------------------------------------------------
module clti_regs
    import clti_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_loc    i_loc,
    output t_result o_result
);

    logic [31:0] r_soft, n_soft;
    logic [63:0] r_cmp,  n_cmp;
    logic [63:0] r_time, n_time;
    logic [63:0] time_inc;
    logic [63:0] src;
    logic [5:0]  sh;

    assign time_inc = r_time + 64'd1;
    assign sh       = {i_loc.lane, 3'b000};

    always_comb begin
        unique case (i_loc.region)
            REG_SOFT: src = {32'd0, r_soft};
            REG_CMP:  src = r_cmp;
            REG_TIME: src = r_time;
            default:  src = 64'd0;
        endcase
    end

    always_comb begin
        n_soft   = r_soft;
        n_cmp    = r_cmp;
        n_time   = r_time;
        o_result = '0;
        unique case (i_item.command)
            CMD_TICK: begin
                n_time = time_inc;
                o_result.timer_pending = i_item.timer_irq_enable && (r_cmp != 64'd0)
                                         && (time_inc >= r_cmp);
                o_result.soft_pending  = i_item.soft_irq_enable && (r_soft != 32'd0);
            end
            CMD_READ: begin
                if (i_loc.region == REG_NONE) begin
                    o_result.bad_offset = 1'b1;
                end else begin
                    o_result.read_byte = src[sh +: 8];
                end
            end
            CMD_WRITE: begin
                unique case (i_loc.region)
                    REG_SOFT: n_soft[{i_loc.lane[1:0], 3'b000} +: 8] = i_item.write_byte;
                    REG_CMP:  n_cmp[sh +: 8]  = i_item.write_byte;
                    REG_TIME: n_time[sh +: 8] = i_item.write_byte;
                    default:  o_result.bad_offset = 1'b1;
                endcase
            end
            default: begin
                // unused command: no effect, all-zero word
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft <= 32'd0;
            r_cmp  <= 64'd0;
            r_time <= 64'd0;
        end else if (i_fire) begin
            r_soft <= n_soft;
            r_cmp  <= n_cmp;
            r_time <= n_time;
        end
    end

endmodule

// ----- rtl/core_local_timer_interruptor_core.sv -----
// ---------------------------------------------------------------------------
// core_local_timer_interruptor_core
// Core-local interruptor: byte-wide access to soft word, compare and time.
// Registers: the request is held in the input register, its result in the response register.
// Throughput: one word per cycle unless output stalls; set by both registers,
// with register update, 64-bit increment and compare in the single stage.
// Reset (synchronous, active low) clears soft word, compare, time and both valids.
// ---------------------------------------------------------------------------
module core_local_timer_interruptor_core
    import clti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    clti_in_if.sink    i_in,
    clti_out_if.source o_out
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    adv;
    logic    fire;
    t_loc    loc;
    t_result result;

    assign adv        = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && adv;
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.command          <= i_in.command;
            r_in.offset           <= i_in.offset;
            r_in.write_byte       <= i_in.write_byte;
            r_in.timer_irq_enable <= i_in.timer_irq_enable;
            r_in.soft_irq_enable  <= i_in.soft_irq_enable;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    clti_decode u_decode (
        .i_offset (r_in.offset),
        .o_loc    (loc)
    );

    clti_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_loc    (loc),
        .o_result (result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.read_byte     = r_out.read_byte;
    assign o_out.bad_offset    = r_out.bad_offset;
    assign o_out.timer_pending = r_out.timer_pending;
    assign o_out.soft_pending  = r_out.soft_pending;

    // a held input word is not dropped while the response side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_out.valid && !o_out.ready) |=> r_in_valid)
        else $error("input word lost during stall");

    // a write answers with no data and no interrupt pulses
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.command == CMD_WRITE) |=>
        (o_out.valid && o_out.read_byte == 8'd0 && !o_out.timer_pending
         && !o_out.soft_pending))
        else $error("write response not quiet");

    // an access outside all windows flags an error
    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && loc.region == REG_NONE
         && (r_in.command == CMD_READ || r_in.command == CMD_WRITE)) |=>
        (o_out.valid && o_out.bad_offset && o_out.read_byte == 8'd0))
        else $error("bad offset not flagged");

    // a tick never carries an error flag
    a_tick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.command == CMD_TICK) |=> (o_out.valid && !o_out.bad_offset))
        else $error("tick flagged as bad offset");

endmodule
